@@ hw/rtl/fwu_pkg.sv @@
// ----------------------------------------------------------------------------
// Firmware update receiver package
// Shared types, codes and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package fwu_pkg;

  localparam int unsigned BlockSize  = 4096;
  localparam int unsigned BlockShift = $clog2(BlockSize);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcSeed = 32'hFFFF_FFFF;

  localparam logic [31:0] MaxImageReset    = 32'd8388608;
  localparam logic [31:0] StagingBaseReset = 32'd0;

  localparam logic [12:0] StartMinLen  = 13'd9;
  localparam logic [12:0] HeaderMinLen = 13'd3;

  localparam logic [31:0] ErrTooLarge   = 32'd0;
  localparam logic [31:0] ErrWriteFail  = 32'd1;
  localparam logic [31:0] ErrCopyFail   = 32'd2;

  typedef enum logic [2:0] {
    CmdStart  = 3'd0,
    CmdHeader = 3'd1,
    CmdByte   = 3'd2,
    CmdVerify = 3'd3,
    CmdFinish = 3'd4,
    CmdAbort  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KindAck  = 2'd0,
    KindData = 2'd1,
    KindNack = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActErase   = 2'd1,
    ActRestore = 2'd2,
    ActReboot  = 2'd3
  } action_e;

  typedef enum logic {
    RegMaxImage    = 1'b0,
    RegStagingBase = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  len;
    logic [31:0] word;
    logic [31:0] addr;
    action_e     action;
  } resp_t;

  typedef struct packed {
    logic seed;
    logic update;
  } crc_ctrl_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/fwu_crc32.sv @@
// ----------------------------------------------------------------------------
// Firmware update CRC-32 register
// Holds the running reflected CRC-32; seeds it or folds in one byte a cycle.
// ----------------------------------------------------------------------------
module fwu_crc32 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fwu_pkg::crc_ctrl_t  ctrl_i,
  input  logic [7:0]          data_i,
  output logic [31:0]         crc_o
);

  logic [31:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.seed) begin
      crc_d = fwu_pkg::CrcSeed;
    end else if (ctrl_i.update) begin
      crc_d = fwu_pkg::crc32_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= fwu_pkg::CrcSeed;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

@@ hw/rtl/fwu_ctrl.sv @@
// ----------------------------------------------------------------------------
// Firmware update session control
// Decodes each command transaction, updates session state and forms the reply, if any.
// ----------------------------------------------------------------------------
module fwu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               accept_i,
  input  logic [2:0]         cmd_i,
  input  logic [12:0]        frame_len_i,
  input  logic [31:0]        image_size_i,
  input  logic [31:0]        expected_crc_i,
  input  logic [15:0]        block_index_i,
  input  logic               write_ok_i,
  input  logic               last_byte_i,
  input  logic               copy_ok_i,
  input  logic [31:0]        crc_i,
  output fwu_pkg::crc_ctrl_t crc_ctrl_o,
  output logic               res_valid_o,
  output fwu_pkg::resp_t     res_o
);

  logic [31:0] max_image_q, staging_base_q;
  logic        active_q, active_d;
  logic        crc_en_q, crc_en_d;
  logic [31:0] target_crc_q, target_crc_d;
  logic [15:0] block_total_q, block_total_d;
  logic [15:0] blocks_done_q, blocks_done_d;

  logic [32:0] size_round;
  logic [32:0] nblk;
  logic [15:0] nblk_sat;
  logic [31:0] blk_offset;
  logic [31:0] crc_final;
  fwu_pkg::crc_ctrl_t crc_ctrl;

  assign size_round = {1'b0, image_size_i} + 33'(fwu_pkg::BlockSize - 1);
  assign nblk       = size_round >> fwu_pkg::BlockShift;
  assign nblk_sat   = (|nblk[32:16]) ? 16'hFFFF : nblk[15:0];
  assign blk_offset = 32'({16'd0, block_index_i} << fwu_pkg::BlockShift);
  assign crc_final  = ~crc_i;

  always_comb begin
    active_d      = active_q;
    crc_en_d      = crc_en_q;
    target_crc_d  = target_crc_q;
    block_total_d = block_total_q;
    blocks_done_d = blocks_done_q;
    crc_ctrl      = '0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    res_o.kind    = fwu_pkg::KindAck;
    res_o.action  = fwu_pkg::ActNone;
    unique case (fwu_pkg::cmd_e'(cmd_i))
      fwu_pkg::CmdStart: begin
        if (frame_len_i >= fwu_pkg::StartMinLen) begin
          target_crc_d = expected_crc_i;
          res_valid_o  = 1'b1;
          if (image_size_i == 32'd0 || image_size_i > max_image_q) begin
            res_o.kind = fwu_pkg::KindNack;
            res_o.len  = 3'd1;
            res_o.word = fwu_pkg::ErrTooLarge;
          end else begin
            active_d      = 1'b1;
            crc_en_d      = 1'b0;
            blocks_done_d = 16'd0;
            block_total_d = nblk_sat;
            crc_ctrl.seed = 1'b1;
            res_o.kind    = fwu_pkg::KindData;
            res_o.len     = 3'd4;
            res_o.word    = {nblk_sat, 16'(fwu_pkg::BlockSize)};
            res_o.action  = fwu_pkg::ActErase;
          end
        end
      end
      fwu_pkg::CmdHeader: begin
        crc_en_d = 1'b0;
        if (active_q && frame_len_i >= fwu_pkg::HeaderMinLen &&
            block_index_i < block_total_q) begin
          res_valid_o = 1'b1;
          if (!write_ok_i) begin
            res_o.kind = fwu_pkg::KindNack;
            res_o.len  = 3'd1;
            res_o.word = fwu_pkg::ErrWriteFail;
          end else begin
            res_o.kind = fwu_pkg::KindData;
            res_o.len  = 3'd2;
            res_o.word = {16'd0, block_index_i};
            res_o.addr = staging_base_q + blk_offset;
            if (block_index_i == blocks_done_q) begin
              blocks_done_d = blocks_done_q + 16'd1;
              crc_en_d      = (frame_len_i != fwu_pkg::HeaderMinLen);
            end
          end
        end
      end
      fwu_pkg::CmdByte: begin
        if (active_q && crc_en_q) begin
          crc_ctrl.update = 1'b1;
          if (last_byte_i) begin
            crc_en_d = 1'b0;
          end
        end
      end
      fwu_pkg::CmdVerify: begin
        if (active_q) begin
          res_valid_o = 1'b1;
          res_o.kind  = (crc_final == target_crc_q) ? fwu_pkg::KindData
                                                    : fwu_pkg::KindNack;
          res_o.len   = 3'd4;
          res_o.word  = crc_final;
        end
      end
      fwu_pkg::CmdFinish: begin
        if (active_q) begin
          res_valid_o = 1'b1;
          if (copy_ok_i) begin
            res_o.action = fwu_pkg::ActReboot;
          end else begin
            active_d     = 1'b0;
            crc_en_d     = 1'b0;
            res_o.kind   = fwu_pkg::KindNack;
            res_o.len    = 3'd1;
            res_o.word   = fwu_pkg::ErrCopyFail;
            res_o.action = fwu_pkg::ActRestore;
          end
        end
      end
      fwu_pkg::CmdAbort: begin
        if (active_q) begin
          res_valid_o  = 1'b1;
          active_d     = 1'b0;
          crc_en_d     = 1'b0;
          res_o.action = fwu_pkg::ActRestore;
        end
      end
      default: begin
      end
    endcase
  end

  assign crc_ctrl_o.seed   = crc_ctrl.seed & accept_i;
  assign crc_ctrl_o.update = crc_ctrl.update & accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_image_q    <= fwu_pkg::MaxImageReset;
      staging_base_q <= fwu_pkg::StagingBaseReset;
    end else if (cfg_we_i) begin
      unique case (fwu_pkg::reg_idx_e'(cfg_idx_i))
        fwu_pkg::RegMaxImage:    max_image_q    <= cfg_wdata_i;
        fwu_pkg::RegStagingBase: staging_base_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      crc_en_q      <= 1'b0;
      target_crc_q  <= 32'd0;
      block_total_q <= 16'd0;
      blocks_done_q <= 16'd0;
    end else if (accept_i) begin
      active_q      <= active_d;
      crc_en_q      <= crc_en_d;
      target_crc_q  <= target_crc_d;
      block_total_q <= block_total_d;
      blocks_done_q <= blocks_done_d;
    end
  end

`ifndef SYNTHESIS
  a_crc_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(crc_ctrl_o.seed && crc_ctrl_o.update))
    else $error("crc seed and update together");

  a_update_in_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_ctrl_o.update |-> (active_q && crc_en_q))
    else $error("crc update outside an armed block");

  a_done_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && active_q && blocks_done_d != blocks_done_q && !crc_ctrl_o.seed)
      |-> (blocks_done_q < block_total_q))
    else $error("blocks_done advanced past block_total");
`endif

endmodule

@@ hw/rtl/fwu_resp_reg.sv @@
// ----------------------------------------------------------------------------
// Firmware update reply register
// Holds one reply transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module fwu_resp_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fwu_pkg::resp_t data_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output fwu_pkg::resp_t data_o
);

  logic           valid_q, valid_d;
  fwu_pkg::resp_t data_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  a_push_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("reply pushed into an occupied register");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled reply lost or changed");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> valid_q)
    else $error("pushed reply not presented");
`endif

endmodule

@@ hw/rtl/firmware_update_receiver.sv @@
// ----------------------------------------------------------------------------
// Firmware update receiver
// Command stream decoder with CRC-32 image check and a registered reply.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    cmd .. copy_ok
//   out      output     out_valid_o / out_ready_i  resp_kind .. action
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One command transaction is taken per cycle while in_ready_o is high; its
// reply, if any, appears from the reply register in the next cycle. in_ready_o
// is low only while a reply waits and out_ready_i is low. Reset clears the
// session and seeds the CRC; the block is ready straight out of reset.
// ----------------------------------------------------------------------------
module firmware_update_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [12:0] frame_len_i,
  input  logic [31:0] image_size_i,
  input  logic [31:0] expected_crc_i,
  input  logic [15:0] block_index_i,
  input  logic        write_ok_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        copy_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  resp_kind_o,
  output logic [2:0]  resp_len_o,
  output logic [31:0] resp_word_o,
  output logic [31:0] flash_addr_o,
  output logic [1:0]  action_o
);

  logic               accept;
  logic               res_valid;
  logic               space;
  logic [31:0]        crc;
  fwu_pkg::crc_ctrl_t crc_ctrl;
  fwu_pkg::resp_t     res;
  fwu_pkg::resp_t     resp;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  fwu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .frame_len_i    (frame_len_i),
    .image_size_i   (image_size_i),
    .expected_crc_i (expected_crc_i),
    .block_index_i  (block_index_i),
    .write_ok_i     (write_ok_i),
    .last_byte_i    (last_byte_i),
    .copy_ok_i      (copy_ok_i),
    .crc_i          (crc),
    .crc_ctrl_o     (crc_ctrl),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  fwu_crc32 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (data_byte_i),
    .crc_o  (crc)
  );

  fwu_resp_reg u_resp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (resp)
  );

  assign resp_kind_o  = resp.kind;
  assign resp_len_o   = resp.len;
  assign resp_word_o  = resp.word;
  assign flash_addr_o = resp.addr;
  assign action_o     = resp.action;

endmodule

@@ sim/tb_firmware_update_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Firmware update receiver testbench
// Feeds command transactions through a randomly idling driver and checks
// every reply against a cycle-free predictor of the session, block and CRC-32
// rules. The run starts with a directed sequence, then moves through several
// register settings with random well-formed update sessions mixed with noise.
// ----------------------------------------------------------------------------
module tb_firmware_update_receiver;

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] frame_len;
    logic [31:0] image_size;
    logic [31:0] expected_crc;
    logic [15:0] block_index;
    logic        write_ok;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        copy_ok;
  } cmd_item_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = 1'b0;
  logic [31:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i          = '0;
  logic [12:0] frame_len_i    = '0;
  logic [31:0] image_size_i   = '0;
  logic [31:0] expected_crc_i = '0;
  logic [15:0] block_index_i  = '0;
  logic        write_ok_i     = 1'b0;
  logic [7:0]  data_byte_i    = '0;
  logic        last_byte_i    = 1'b0;
  logic        copy_ok_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  resp_kind_o;
  logic [2:0]  resp_len_o;
  logic [31:0] resp_word_o;
  logic [31:0] flash_addr_o;
  logic [1:0]  action_o;

  firmware_update_receiver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .frame_len_i    (frame_len_i),
    .image_size_i   (image_size_i),
    .expected_crc_i (expected_crc_i),
    .block_index_i  (block_index_i),
    .write_ok_i     (write_ok_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .copy_ok_i      (copy_ok_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .resp_kind_o    (resp_kind_o),
    .resp_len_o     (resp_len_o),
    .resp_word_o    (resp_word_o),
    .flash_addr_o   (flash_addr_o),
    .action_o       (action_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_item_t       pending_cmds[$];
  fwu_pkg::resp_t  expected_replies[$];
  cmd_item_t       cmd_on_bus;
  fwu_pkg::resp_t  got_reply;
  fwu_pkg::resp_t  want_reply;
  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int          error_count     = 0;
  int          cmds_accepted   = 0;
  int          replies_checked = 0;
  int          sessions_armed  = 0;
  int          crc_matches     = 0;
  int unsigned quiet_cycles    = 0;

  // Register copies and session state of the predictor
  logic [31:0] cfg_max_image    = fwu_pkg::MaxImageReset;
  logic [31:0] cfg_staging_base = fwu_pkg::StagingBaseReset;
  logic        sess_active      = 1'b0;
  logic [31:0] image_bytes      = '0;
  logic [31:0] target_crc       = '0;
  logic [31:0] run_crc          = fwu_pkg::CrcSeed;
  logic [15:0] blk_total        = '0;
  logic [15:0] blk_done         = '0;
  logic [31:0] bytes_done       = '0;
  logic        crc_on           = 1'b0;

  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = (r >> 1) ^ fwu_pkg::CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic bit predict_reply(input cmd_item_t it, output fwu_pkg::resp_t rsp);
    logic [63:0] nblk;
    logic [31:0] dlen;
    logic [31:0] crc_out;
    rsp = '0;
    predict_reply = 1'b0;
    case (it.cmd)
      fwu_pkg::CmdStart: begin
        if (it.frame_len >= fwu_pkg::StartMinLen) begin
          predict_reply = 1'b1;
          image_bytes = it.image_size;
          target_crc = it.expected_crc;
          if (it.image_size == 32'd0 || it.image_size > cfg_max_image) begin
            rsp.kind = fwu_pkg::KindNack;
            rsp.len = 3'd1;
            rsp.word = fwu_pkg::ErrTooLarge;
          end else begin
            nblk = (64'(it.image_size) + 64'(fwu_pkg::BlockSize) - 64'd1)
                   >> fwu_pkg::BlockShift;
            sess_active = 1'b1;
            bytes_done = '0;
            run_crc = fwu_pkg::CrcSeed;
            blk_total = (nblk > 64'hFFFF) ? 16'hFFFF : nblk[15:0];
            blk_done = '0;
            crc_on = 1'b0;
            sessions_armed++;
            rsp.kind = fwu_pkg::KindData;
            rsp.len = 3'd4;
            rsp.word = {blk_total, 16'(fwu_pkg::BlockSize)};
            rsp.action = fwu_pkg::ActErase;
          end
        end
      end
      fwu_pkg::CmdHeader: begin
        crc_on = 1'b0;
        if (sess_active && it.frame_len >= fwu_pkg::HeaderMinLen &&
            it.block_index < blk_total) begin
          predict_reply = 1'b1;
          if (!it.write_ok) begin
            rsp.kind = fwu_pkg::KindNack;
            rsp.len = 3'd1;
            rsp.word = fwu_pkg::ErrWriteFail;
          end else begin
            rsp.kind = fwu_pkg::KindData;
            rsp.len = 3'd2;
            rsp.word = {16'd0, it.block_index};
            rsp.addr = cfg_staging_base + ({16'd0, it.block_index} << fwu_pkg::BlockShift);
            if (it.block_index == blk_done) begin
              dlen = {19'd0, it.frame_len} - 32'd3;
              blk_done = blk_done + 16'd1;
              bytes_done = bytes_done + dlen;
              crc_on = (dlen != 32'd0);
            end
          end
        end
      end
      fwu_pkg::CmdByte: begin
        if (sess_active && crc_on) begin
          run_crc = crc32_step(run_crc, it.data_byte);
          if (it.last_byte) begin
            crc_on = 1'b0;
          end
        end
      end
      fwu_pkg::CmdVerify: begin
        if (sess_active) begin
          predict_reply = 1'b1;
          crc_out = ~run_crc;
          if (crc_out == target_crc) begin
            crc_matches++;
          end
          rsp.kind = (crc_out == target_crc) ? fwu_pkg::KindData : fwu_pkg::KindNack;
          rsp.len = 3'd4;
          rsp.word = crc_out;
        end
      end
      fwu_pkg::CmdFinish: begin
        if (sess_active) begin
          predict_reply = 1'b1;
          if (it.copy_ok) begin
            rsp.kind = fwu_pkg::KindAck;
            rsp.action = fwu_pkg::ActReboot;
          end else begin
            sess_active = 1'b0;
            crc_on = 1'b0;
            rsp.kind = fwu_pkg::KindNack;
            rsp.len = 3'd1;
            rsp.word = fwu_pkg::ErrCopyFail;
            rsp.action = fwu_pkg::ActRestore;
          end
        end
      end
      fwu_pkg::CmdAbort: begin
        if (sess_active) begin
          predict_reply = 1'b1;
          sess_active = 1'b0;
          crc_on = 1'b0;
          rsp.kind = fwu_pkg::KindAck;
          rsp.action = fwu_pkg::ActRestore;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic cmd_item_t make_cmd(input logic [2:0] c, input logic [12:0] flen);
    cmd_item_t it;
    it.cmd = c;
    it.frame_len = flen;
    it.image_size = $urandom;
    it.expected_crc = $urandom;
    it.block_index = 16'($urandom);
    it.write_ok = 1'($urandom);
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.copy_ok = 1'($urandom);
    return it;
  endfunction

  function automatic cmd_item_t noise_cmd();
    return make_cmd(3'($urandom_range(0, 5)), 13'($urandom_range(0, 4099)));
  endfunction

  // Driver: hold the transaction until accepted, then advance or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cmds_accepted++;
        if (predict_reply(cmd_on_bus, want_reply)) begin
          expected_replies.push_back(want_reply);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cmd_on_bus = pending_cmds.pop_front();
          cmd_i          <= cmd_on_bus.cmd;
          frame_len_i    <= cmd_on_bus.frame_len;
          image_size_i   <= cmd_on_bus.image_size;
          expected_crc_i <= cmd_on_bus.expected_crc;
          block_index_i  <= cmd_on_bus.block_index;
          write_ok_i     <= cmd_on_bus.write_ok;
          data_byte_i    <= cmd_on_bus.data_byte;
          last_byte_i    <= cmd_on_bus.last_byte;
          copy_ok_i      <= cmd_on_bus.copy_ok;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_reply.kind   = fwu_pkg::kind_e'(resp_kind_o);
      got_reply.len    = resp_len_o;
      got_reply.word   = resp_word_o;
      got_reply.addr   = flash_addr_o;
      got_reply.action = fwu_pkg::action_e'(action_o);
      if (expected_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected reply kind=%0d len=%0d word=%h addr=%h action=%0d",
                 $time, resp_kind_o, resp_len_o, resp_word_o, flash_addr_o, action_o);
      end else begin
        want_reply = expected_replies.pop_front();
        replies_checked++;
        if (got_reply !== want_reply) begin
          error_count++;
          $display("%0t: reply mismatch expected kind=%0d len=%0d word=%h addr=%h action=%0d",
                   $time, want_reply.kind, want_reply.len, want_reply.word, want_reply.addr,
                   want_reply.action);
          $display("%0t:                  actual kind=%0d len=%0d word=%h addr=%h action=%0d",
                   $time, resp_kind_o, resp_len_o, resp_word_o, flash_addr_o, action_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input fwu_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == fwu_pkg::RegMaxImage) begin
      cfg_max_image = val;
    end else begin
      cfg_staging_base = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending_cmds.size() != 0 || in_valid_i || expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // One update session: start, in-order blocks with data, verify, then finish or abort
  task automatic queue_session(inout int queued);
    cmd_item_t   sess[$];
    cmd_item_t   start_cmd;
    cmd_item_t   it;
    logic [31:0] crc;
    int          nblk;
    int          n;
    nblk = $urandom_range(1, 3);
    crc = fwu_pkg::CrcSeed;
    start_cmd = make_cmd(fwu_pkg::CmdStart, 13'($urandom_range(9, 40)));
    if ($urandom_range(7) != 0) begin
      start_cmd.image_size = (nblk - 1) * fwu_pkg::BlockSize +
                             $urandom_range(1, fwu_pkg::BlockSize);
    end
    for (int blk = 0; blk < nblk; blk++) begin
      if ($urandom_range(9) == 0) begin
        it = make_cmd(fwu_pkg::CmdHeader, 13'($urandom_range(3, 20)));
        it.block_index = 16'(blk);
        it.write_ok = 1'b0;
        sess.push_back(it);
      end
      if (blk > 0 && $urandom_range(5) == 0) begin
        it = make_cmd(fwu_pkg::CmdHeader, 13'($urandom_range(3, 20)));
        it.block_index = 16'(blk - 1);
        it.write_ok = 1'b1;
        sess.push_back(it);
      end
      n = ($urandom_range(15) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 12);
      it = make_cmd(fwu_pkg::CmdHeader, 13'(3 + n));
      it.block_index = 16'(blk);
      it.write_ok = 1'b1;
      sess.push_back(it);
      for (int j = 0; j < n; j++) begin
        it = make_cmd(fwu_pkg::CmdByte, 13'($urandom_range(0, 4099)));
        it.last_byte = (j == n - 1);
        crc = crc32_step(crc, it.data_byte);
        sess.push_back(it);
      end
      if ($urandom_range(7) == 0) begin
        sess.push_back(noise_cmd());
      end
    end
    sess.push_back(make_cmd(fwu_pkg::CmdVerify, 13'($urandom_range(0, 4099))));
    if ($urandom_range(2) == 0) begin
      sess.push_back(make_cmd(fwu_pkg::CmdAbort, 13'($urandom_range(0, 4099))));
    end else begin
      sess.push_back(make_cmd(fwu_pkg::CmdFinish, 13'($urandom_range(0, 4099))));
    end
    if ($urandom_range(3) != 0) begin
      start_cmd.expected_crc = ~crc;
    end
    pending_cmds.push_back(start_cmd);
    foreach (sess[i]) begin
      pending_cmds.push_back(sess[i]);
    end
    queued += sess.size() + 1;
  endtask

  task automatic run_phase(input logic [31:0] max_img, input logic [31:0] base,
                           input int s_idle, input int r_stall, input int n_items);
    int queued;
    queued = 0;
    wait_quiet();
    write_reg(fwu_pkg::RegMaxImage, max_img);
    write_reg(fwu_pkg::RegStagingBase, base);
    sender_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    while (queued < n_items) begin
      if ($urandom_range(4) == 0) begin
        pending_cmds.push_back(noise_cmd());
        queued++;
      end else begin
        queue_session(queued);
      end
    end
  endtask

  initial begin
    cmd_item_t   it;
    logic [31:0] dcrc;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dcrc = crc32_step(crc32_step(crc32_step(fwu_pkg::CrcSeed, 8'h00), 8'hFF), 8'hA5);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd5);  it.block_index = '0; it.write_ok = 1'b1;
    pending_cmds.push_back(it);
    pending_cmds.push_back(make_cmd(fwu_pkg::CmdVerify, 13'd0));
    it = make_cmd(fwu_pkg::CmdFinish, 13'd1);  it.copy_ok = 1'b1;
    pending_cmds.push_back(it);
    pending_cmds.push_back(make_cmd(fwu_pkg::CmdAbort, 13'd0));
    pending_cmds.push_back(make_cmd(CmdSpare6, 13'd9));
    pending_cmds.push_back(make_cmd(CmdSpare7, 13'd9));
    it = make_cmd(fwu_pkg::CmdStart, 13'd8);   it.image_size = 32'd100;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdStart, 13'd9);   it.image_size = 32'd0;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdStart, 13'd9);   it.image_size = 32'hFFFF_FFFF;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdStart, 13'd9);   it.image_size = fwu_pkg::MaxImageReset;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdStart, 13'd4099);
    it.image_size = 32'd4097; it.expected_crc = ~dcrc;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd2);  it.block_index = '0; it.write_ok = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd3);  it.block_index = 16'hFFFF; it.write_ok = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd5);  it.block_index = '0; it.write_ok = 1'b0;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd5);  it.block_index = '0; it.write_ok = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdByte, 13'd0);    it.data_byte = 8'h00; it.last_byte = 1'b0;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdByte, 13'd0);    it.data_byte = 8'hFF; it.last_byte = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd3);  it.block_index = '0; it.write_ok = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdHeader, 13'd4099);
    it.block_index = 16'd1; it.write_ok = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdByte, 13'd0);    it.data_byte = 8'hA5; it.last_byte = 1'b1;
    pending_cmds.push_back(it);
    pending_cmds.push_back(make_cmd(fwu_pkg::CmdVerify, 13'd1));
    it = make_cmd(fwu_pkg::CmdFinish, 13'd0);  it.copy_ok = 1'b1;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdFinish, 13'd0);  it.copy_ok = 1'b0;
    pending_cmds.push_back(it);
    it = make_cmd(fwu_pkg::CmdStart, 13'd9);
    it.image_size = 32'd1; it.expected_crc = 32'hFFFF_FFFF;
    pending_cmds.push_back(it);
    pending_cmds.push_back(make_cmd(fwu_pkg::CmdVerify, 13'd0));
    pending_cmds.push_back(make_cmd(fwu_pkg::CmdAbort, 13'd0));

    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 140);
    run_phase(32'd12000, 32'h0800_0000, 76, 0, 140);
    run_phase(32'd5000, $urandom, 0, 76, 140);
    run_phase(32'd0, 32'd0, 28, 28, 50);
    run_phase(fwu_pkg::MaxImageReset, 32'h7FFF_F000, 28, 28, 90);

    wait_quiet();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d commands over six register settings; %0d replies checked,",
             cmds_accepted, replies_checked);
    $display("%0d sessions armed, %0d CRC matches, %0d mismatches",
             sessions_armed, crc_matches, error_count);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fwu_pkg.sv
hw/rtl/fwu_crc32.sv
hw/rtl/fwu_ctrl.sv
hw/rtl/fwu_resp_reg.sv
hw/rtl/firmware_update_receiver.sv
sim/tb_firmware_update_receiver.sv
